// ===== hdl/trrb_pkg.sv =====
// Package for the trace record ring buffer: operation and status codes,
// configuration register indexes, field widths and the result record type.
// No dependencies.
package trrb_pkg;

    localparam int LEN_W  = 13;
    localparam int BYTE_W = 8;
    localparam int ROFF_W = 12;
    localparam int POFF_W = 12;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 3;
    localparam int CNT_W  = 33;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_DISABLED = 3'd2,
        ST_STORED   = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_PIECE    = 3'd5,
        ST_READ     = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ENABLE          = 3'd0,
        CFG_BUF_SIZE        = 3'd1,
        CFG_FLUSH_THRESHOLD = 3'd2,
        CFG_SKIP_WHEN_FULL  = 3'd3,
        CFG_FILE_SIZE_LIMIT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        status_t             status;
        logic [POFF_W-1:0]   offset;
        logic [LEN_W-1:0]    length;
        logic                rotate;
    } result_t;

endpackage

// ===== hdl/trrb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module trrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/trace_record_ring_buffer_unit.sv =====
// Trace record ring buffer: byte ring for variable-length records with
// threshold drain and file rotation flag. Uses trrb_pkg and trrb_ram.
//
// Channel   Signals                                          Handshake
// command   operation record_length data_byte read_offset    start, taken when busy low
// result    status piece_offset piece_length read_data       strobe, one cycle each,
//           file_rotate last                                 no back-pressure
// config    cfg_write cfg_index cfg_data                     write on cfg_write
//
// An item's first result appears in the cycle after its transfer. An item gives one
// to three results, one per cycle from the result register queue; busy is high while
// more than one is still to go, so single-result items run one per cycle and a longer
// item holds off the next until one result is left. Reset clears pointers, counts and
// the queue; the ring store needs no clearing pass. The receiver cannot stall.
module trace_record_ring_buffer_unit
    import trrb_pkg::*;
#(
    parameter int RING_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [LEN_W-1:0]  record_length,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [ROFF_W-1:0] read_offset,
    output logic              strobe,
    output logic [2:0]        status,
    output logic [POFF_W-1:0] piece_offset,
    output logic [LEN_W-1:0]  piece_length,
    output logic [BYTE_W-1:0] read_data,
    output logic              file_rotate,
    output logic              last,
    input  logic              cfg_write,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int OFF_W   = $clog2(RING_BYTES + 1);
    localparam int AW      = $clog2(RING_BYTES);
    localparam int SW      = (OFF_W > LEN_W) ? OFF_W : LEN_W;
    localparam int RSH     = 25;
    localparam int RECIP_W = RSH - 3;
    localparam int RECIP   = (2**RSH + RING_BYTES - 1) / RING_BYTES;

    logic                  enable_reg, enable_next;
    logic [LEN_W-1:0]      buf_size_reg, buf_size_next;
    logic [LEN_W-1:0]      threshold_reg, threshold_next;
    logic                  skip_reg, skip_next;
    logic [CFG_W-1:0]      limit_reg, limit_next;
    logic [OFF_W-1:0]      head_reg, head_next;
    logic [OFF_W-1:0]      tail_reg, tail_next;
    logic [OFF_W-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]      remain_reg, remain_next;
    logic                  open_reg, open_next;
    result_t               res_reg [3];
    result_t               res_next [3];
    logic [1:0]            fill_reg, fill_next;

    logic                  accept;
    logic [OFF_W-1:0]      size;
    logic [SW-1:0]         bs_ext;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [BYTE_W-1:0]     ram_rdata;

    logic [OFF_W-1:0]      head_a;
    logic [OFF_W-1:0]      used_a;
    logic [OFF_W:0]        head_inc;
    logic                  do_drain;
    logic                  drained;
    logic [1:0]            npieces;
    result_t               piece_a;
    result_t               piece_b;
    logic [OFF_W-1:0]      off_a;
    logic [OFF_W-1:0]      len_a;
    logic [OFF_W-1:0]      len_b;
    logic [CNT_W:0]        cnt_sum;
    logic [CNT_W-1:0]      cnt_sat;
    logic                  rotate;
    logic                  fits;
    logic                  thr_hit;

    assign accept = start && !busy;
    assign busy   = fill_reg[1];
    assign bs_ext = SW'(buf_size_reg);

    always_comb
    begin
        if (bs_ext == '0)
        begin
            size = OFF_W'(1);
        end
        else if (bs_ext > SW'(RING_BYTES))
        begin
            size = OFF_W'(RING_BYTES);
        end
        else
        begin
            size = OFF_W'(bs_ext);
        end
    end

    generate
        if (RING_BYTES >= 2**ROFF_W)
        begin : g_rd_direct
            assign rd_addr = AW'(read_offset);
        end
        else
        begin : g_rd_mod
            logic [ROFF_W+RECIP_W-1:0]     rd_prod;
            logic [ROFF_W+RECIP_W-RSH-1:0] rd_quot;
            logic [ROFF_W-1:0]             rd_sub;
            logic [ROFF_W-1:0]             rd_rem;
            assign rd_prod = {{RECIP_W{1'b0}}, read_offset}
                           * {{ROFF_W{1'b0}}, RECIP_W'(RECIP)};
            assign rd_quot = rd_prod[ROFF_W+RECIP_W-1:RSH];
            assign rd_sub  = ROFF_W'(rd_quot) * ROFF_W'(RING_BYTES);
            assign rd_rem  = read_offset - rd_sub;
            assign rd_addr = AW'(rd_rem);
        end
    endgenerate

    assign wr_addr = (head_reg == size) ? '0 : AW'(head_reg);

    always_comb
    begin
        enable_next    = enable_reg;
        buf_size_next  = buf_size_reg;
        threshold_next = threshold_reg;
        skip_next      = skip_reg;
        limit_next     = limit_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        open_next      = open_reg;
        fill_next      = fill_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        head_a         = head_reg;
        used_a         = used_reg;
        do_drain       = 1'b0;
        piece_a        = '0;
        piece_b        = '0;
        off_a          = '0;
        len_a          = '0;
        len_b          = '0;
        npieces        = 2'd0;

        head_inc = {1'b0, head_reg} + (OFF_W + 1)'(1);
        fits     = ((SW + 1)'(used_reg) + (SW + 1)'(record_length)) < (SW + 1)'(size);

        if (op_t'(operation) == OP_DATA && enable_reg && open_reg)
        begin
            head_a = (head_inc > {1'b0, size}) ? OFF_W'(head_inc - {1'b0, size})
                                               : OFF_W'(head_inc);
            used_a = used_reg + OFF_W'(1);
        end
        thr_hit = SW'(used_a) >= SW'(threshold_reg);

        case (op_t'(operation))
            OP_START:
            begin
                if (enable_reg && fits)
                begin
                    do_drain = (record_length == '0) && thr_hit;
                end
                else if (enable_reg)
                begin
                    do_drain = !skip_reg;
                end
            end
            OP_DATA:
            begin
                do_drain = enable_reg && open_reg && (remain_reg == LEN_W'(1)) && thr_hit;
            end
            OP_FLUSH:
            begin
                do_drain = enable_reg;
            end
            default:
            begin
                do_drain = 1'b0;
            end
        endcase

        drained = do_drain && (used_a != '0);

        if (head_a > tail_reg)
        begin
            npieces = 2'd1;
            off_a   = (tail_reg == size) ? '0 : tail_reg;
            len_a   = head_a - tail_reg;
        end
        else if (size > tail_reg && head_a != '0)
        begin
            npieces = 2'd2;
            off_a   = tail_reg;
            len_a   = size - tail_reg;
            len_b   = head_a;
        end
        else if (size > tail_reg)
        begin
            npieces = 2'd1;
            off_a   = tail_reg;
            len_a   = size - tail_reg;
        end
        else
        begin
            npieces = 2'd1;
            len_a   = head_a;
        end

        cnt_sum = {1'b0, count_reg} + (CNT_W + 1)'(used_a);
        cnt_sat = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
        rotate  = (limit_reg != '0) && (cnt_sat > CNT_W'(limit_reg));

        piece_a.status = ST_PIECE;
        piece_a.offset = POFF_W'(off_a);
        piece_a.length = LEN_W'(len_a);
        piece_a.rotate = rotate && (npieces == 2'd1);
        piece_b.status = ST_PIECE;
        piece_b.offset = '0;
        piece_b.length = LEN_W'(len_b);
        piece_b.rotate = rotate && (npieces == 2'd2);

        if (accept)
        begin
            res_next[0] = '0;
            res_next[1] = '0;
            res_next[2] = '0;
            fill_next   = 2'd1;
            case (op_t'(operation))
                OP_READ:
                begin
                    ram_re             = 1'b1;
                    res_next[0].status = ST_READ;
                end
                OP_START:
                begin
                    if (!enable_reg)
                    begin
                        res_next[0].status = ST_DISABLED;
                    end
                    else if (fits)
                    begin
                        res_next[0].status = ST_ACCEPTED;
                        open_next          = record_length != '0;
                        remain_next        = record_length;
                    end
                    else
                    begin
                        res_next[0].status = ST_DROPPED;
                        open_next          = 1'b0;
                        remain_next        = '0;
                    end
                    if (drained)
                    begin
                        res_next[1] = piece_a;
                        res_next[2] = piece_b;
                        fill_next   = 2'd1 + npieces;
                    end
                end
                OP_DATA:
                begin
                    if (!enable_reg || !open_reg)
                    begin
                        res_next[0].status = ST_IGNORED;
                    end
                    else
                    begin
                        ram_we             = 1'b1;
                        head_next          = head_a;
                        used_next          = used_a;
                        remain_next        = remain_reg - LEN_W'(1);
                        open_next          = remain_reg != LEN_W'(1);
                        res_next[0].status = ST_STORED;
                        if (drained)
                        begin
                            res_next[1] = piece_a;
                            res_next[2] = piece_b;
                            fill_next   = 2'd1 + npieces;
                        end
                    end
                end
                default:
                begin
                    if (!enable_reg)
                    begin
                        res_next[0].status = ST_DISABLED;
                    end
                    else if (drained)
                    begin
                        res_next[0] = piece_a;
                        res_next[1] = piece_b;
                        fill_next   = npieces;
                    end
                    else
                    begin
                        res_next[0].status = ST_EMPTY;
                    end
                end
            endcase
            if (drained)
            begin
                tail_next  = head_a;
                used_next  = '0;
                count_next = rotate ? '0 : cnt_sat;
            end
        end
        else if (fill_reg != 2'd0)
        begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            res_next[2] = '0;
            fill_next   = fill_reg - 2'd1;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLE:
                begin
                    if (cfg_data[0] && !enable_reg)
                    begin
                        head_next   = '0;
                        tail_next   = '0;
                        used_next   = '0;
                        count_next  = '0;
                        open_next   = 1'b0;
                        remain_next = '0;
                    end
                    else if (!cfg_data[0] && enable_reg)
                    begin
                        open_next   = 1'b0;
                        remain_next = '0;
                    end
                    enable_next = cfg_data[0];
                end
                CFG_BUF_SIZE:
                begin
                    if (!enable_reg)
                    begin
                        buf_size_next = cfg_data[LEN_W-1:0];
                    end
                end
                CFG_FLUSH_THRESHOLD:
                begin
                    if (!enable_reg)
                    begin
                        threshold_next = cfg_data[LEN_W-1:0];
                    end
                end
                CFG_SKIP_WHEN_FULL:
                begin
                    if (!enable_reg)
                    begin
                        skip_next = cfg_data[0];
                    end
                end
                CFG_FILE_SIZE_LIMIT:
                begin
                    if (!enable_reg)
                    begin
                        limit_next = cfg_data;
                    end
                end
                default:
                begin
                    enable_next = enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            buf_size_reg  <= LEN_W'(4096);
            threshold_reg <= LEN_W'(2048);
            skip_reg      <= 1'b0;
            limit_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            open_reg      <= 1'b0;
            fill_reg      <= 2'd0;
            res_reg[0]    <= '0;
            res_reg[1]    <= '0;
            res_reg[2]    <= '0;
        end
        else
        begin
            enable_reg    <= enable_next;
            buf_size_reg  <= buf_size_next;
            threshold_reg <= threshold_next;
            skip_reg      <= skip_next;
            limit_reg     <= limit_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            open_reg      <= open_next;
            fill_reg      <= fill_next;
            res_reg       <= res_next;
        end
    end

    trrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign strobe       = fill_reg != 2'd0;
    assign last         = fill_reg == 2'd1;
    assign status       = res_reg[0].status;
    assign piece_offset = res_reg[0].offset;
    assign piece_length = res_reg[0].length;
    assign file_rotate  = res_reg[0].rotate;
    assign read_data    = (res_reg[0].status == ST_READ) ? ram_rdata : '0;

    a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> strobe)
        else $error("busy without a pending result");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> strobe)
        else $error("no result after a transfer");

    a_rotate_last: assert property (@(posedge clk) disable iff (!rst_n)
        file_rotate |-> (strobe && last && status == ST_PIECE))
        else $error("rotation flag off the last drain piece");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        enable_reg |-> (used_reg < size))
        else $error("ring fill reached its size");

endmodule
